FILE: rtl/elp_pkg.sv
package elp_pkg;

	localparam int PAGE_W          = 52;
	localparam int MAX_ALLOC       = 64;
	localparam int MAX_EXTENTS_DEF = 1024;
	localparam int WANT_W          = $clog2(MAX_ALLOC + 1);

	localparam logic [PAGE_W-1:0] PAGE_MASK = {PAGE_W{1'b1}};

	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_RESERVE = 2'd1;
	localparam logic [1:0] CMD_ALLOC   = 2'd2;
	localparam logic [1:0] CMD_FREE    = 2'd3;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_MISS = 2'd1;
	localparam logic [1:0] STS_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [PAGE_W-1:0] page;
		logic [PAGE_W-1:0] count;
		logic              final_req;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0] out_page;
		logic [1:0]        status;
		logic              last;
	} rsp_t;

endpackage

FILE: rtl/elp_ram.sv
module elp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/extent_list_page_allocator_unit.sv
// Extent-list page allocator, first fit.
// req carries one command (load region, reserve page, allocate pages, free page);
// a transfer happens when req_valid is high and req_stall is low. rsp returns the
// results the same way: one result per command, or one per page for a successful
// allocate, with last set on the final one.
// The extent table sits in one synchronous RAM (start, end, link, link flag per
// slot); load appends at the tail, while reserve, allocate and the put-back of
// a free run walk the list from its head, with a read state and then a check
// state, which may write back, for each extent visited. Allocate first sums
// the extents, then takes the pages of each in list order at one page per
// cycle while the output register is free. Free walks the list once for each
// run that it puts back. One command is in work at a time: req_stall stays high
// until its last result is loaded into the output register.
// Reset empties the list, the slot counter and the open free run at once; the
// RAM itself is not cleared. When the receiver stalls, the output register
// holds its result and the sequencer waits for it to drain.
module extent_list_page_allocator_unit #(
	parameter int MAX_EXTENTS = elp_pkg::MAX_EXTENTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  elp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output elp_pkg::rsp_t rsp
);
	import elp_pkg::*;

	localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam int PW = PAGE_W;
	localparam int EW = 2 * PW + IW + 1;
	localparam logic [CW-1:0] SLOTS_MAX = CW'(MAX_EXTENTS);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_EMIT    = 5'd1;
	localparam logic [4:0] S_AP      = 5'd2;
	localparam logic [4:0] S_AP_TL   = 5'd3;
	localparam logic [4:0] S_RV_RD   = 5'd4;
	localparam logic [4:0] S_RV_CK   = 5'd5;
	localparam logic [4:0] S_RV_UNL  = 5'd6;
	localparam logic [4:0] S_RV_SPL  = 5'd7;
	localparam logic [4:0] S_AS_RD   = 5'd8;
	localparam logic [4:0] S_AS_CK   = 5'd9;
	localparam logic [4:0] S_AL_RD   = 5'd10;
	localparam logic [4:0] S_AL_LD   = 5'd11;
	localparam logic [4:0] S_AL_RUN  = 5'd12;
	localparam logic [4:0] S_IN_RD   = 5'd13;
	localparam logic [4:0] S_IN_CK   = 5'd14;
	localparam logic [4:0] S_IN_MG   = 5'd15;
	localparam logic [4:0] S_FR_NEXT = 5'd16;

	logic [4:0]        state_q;
	logic [1:0]        cmd_q;
	logic [PW-1:0]     page_q;
	logic [WANT_W-1:0] want_q;
	logic [WANT_W-1:0] k_q;
	logic [PW:0]       avail_q;
	logic [1:0]        st_q;
	logic [IW-1:0]     cur_q;
	logic              have_q;
	logic [IW-1:0]     prev_q;
	logic              has_prev_q;
	logic [IW-1:0]     nx_q;
	logic [PW-1:0]     s_q;
	logic [PW-1:0]     e_q;
	logic [IW-1:0]     lk_q;
	logic              hl_q;
	logic [PW-1:0]     ps_q;
	logic [PW-1:0]     pe_q;
	logic [PW-1:0]     ins_a_q;
	logic [PW-1:0]     ins_b_q;
	logic              fin_pend_q;
	logic [IW-1:0]     head_q;
	logic              head_valid_q;
	logic [CW-1:0]     slots_q;
	logic [IW-1:0]     tail_q;
	logic [PW-1:0]     run_first_q;
	logic [PW-1:0]     run_limit_q;
	logic              run_open_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic          we;
	logic [IW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic [IW-1:0] raddr;
	logic [EW-1:0] rdata;

	logic [PW-1:0] r_s;
	logic [PW-1:0] r_e;
	logic [IW-1:0] r_lk;
	logic          r_hl;

	logic          accept;
	logic          out_free;
	logic          rsp_load;
	logic          full;
	logic [IW-1:0] new_idx;
	logic [4:0]    ret_state;
	logic [PW-1:0] load_end;
	logic          rv_hit;
	logic          rv_trim;
	logic [PW-1:0] rv_ns;
	logic [PW-1:0] rv_ne;
	logic          mg_ok;
	logic [PW-1:0] mg_end;

	elp_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_EXTENTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign r_s  = rdata[EW-1 -: PW];
	assign r_e  = rdata[EW-1-PW -: PW];
	assign r_lk = rdata[IW:1];
	assign r_hl = rdata[0];

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = out_free && ((state_q == S_EMIT)
	                                || (state_q == S_AL_RUN && s_q < e_q));
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign full      = (slots_q >= SLOTS_MAX);
	assign new_idx   = slots_q[IW-1:0];
	assign ret_state = (cmd_q == CMD_FREE) ? S_FR_NEXT : S_EMIT;
	assign load_end  = (req.count > (PAGE_MASK - req.page)) ? PAGE_MASK
	                                                        : req.page + req.count;

	assign rv_hit  = (r_s <= page_q) && (page_q < r_e);
	assign rv_trim = (page_q == r_s) || ((page_q + 1'b1) == r_e);
	assign rv_ns   = (page_q == r_s) ? r_s + 1'b1 : r_s;
	assign rv_ne   = (page_q == r_s) ? r_e : r_e - 1'b1;
	assign mg_ok   = (r_s <= e_q);
	assign mg_end  = (r_e > e_q) ? r_e : e_q;

	// RAM port control
	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = {s_q, e_q, lk_q, hl_q};
		raddr = cur_q;
		unique case (state_q)
			S_AP: begin
				raddr = tail_q;
				if (!full) begin
					we    = 1'b1;
					waddr = new_idx;
					wdata = {ins_a_q, ins_b_q, {IW{1'b0}}, 1'b0};
				end
			end
			S_AP_TL: begin
				we    = 1'b1;
				waddr = tail_q;
				wdata = {r_s, r_e, nx_q, 1'b1};
			end
			S_RV_CK: begin
				if (rv_hit) begin
					if (rv_trim) begin
						we    = 1'b1;
						wdata = {rv_ns, rv_ne, r_lk, r_hl};
					end else if (!full) begin
						we    = 1'b1;
						waddr = new_idx;
						wdata = {page_q + 1'b1, r_e, r_lk, r_hl};
					end
				end
			end
			S_RV_UNL: begin
				we    = 1'b1;
				waddr = prev_q;
				wdata = {ps_q, pe_q, lk_q, hl_q};
			end
			S_RV_SPL: begin
				we    = 1'b1;
				wdata = {s_q, page_q, nx_q, 1'b1};
			end
			S_AL_RUN: begin
				if (s_q < e_q && out_free) begin
					we    = 1'b1;
					wdata = {s_q + 1'b1, e_q, lk_q, hl_q};
				end
			end
			S_IN_CK: begin
				raddr = r_lk;
				if (r_s == ins_b_q) begin
					we    = 1'b1;
					wdata = {ins_a_q, r_e, r_lk, r_hl};
				end else if (r_e == ins_a_q && !r_hl) begin
					we    = 1'b1;
					wdata = {r_s, ins_b_q, r_lk, r_hl};
				end
			end
			S_IN_MG: begin
				we = 1'b1;
				if (mg_ok) begin
					wdata = {s_q, mg_end, r_lk, r_hl};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			head_valid_q <= 1'b0;
			slots_q      <= '0;
			tail_q       <= '0;
			run_first_q  <= '0;
			run_limit_q  <= '0;
			run_open_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
			fin_pend_q   <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q      <= req.cmd;
						page_q     <= req.page;
						st_q       <= STS_OK;
						cur_q      <= head_q;
						have_q     <= head_valid_q;
						has_prev_q <= 1'b0;
						fin_pend_q <= req.final_req;
						unique case (req.cmd)
							CMD_LOAD: begin
								ins_a_q <= req.page;
								ins_b_q <= load_end;
								state_q <= (load_end > req.page) ? S_AP : S_EMIT;
							end
							CMD_RESERVE: begin
								state_q <= S_RV_RD;
							end
							CMD_ALLOC: begin
								want_q  <= req.count[WANT_W-1:0];
								avail_q <= '0;
								k_q     <= '0;
								if (req.count > PW'(MAX_ALLOC)) begin
									st_q    <= STS_MISS;
									state_q <= S_EMIT;
								end else if (req.count == '0) begin
									state_q <= S_EMIT;
								end else begin
									state_q <= S_AS_RD;
								end
							end
							CMD_FREE: begin
								state_q <= S_FR_NEXT;
								if (req.page == PAGE_MASK) begin
									st_q <= STS_MISS;
								end else if (run_open_q && run_first_q != '0
								             && (req.page + 1'b1) == run_first_q) begin
									run_first_q <= req.page;
								end else if (run_open_q && req.page == run_limit_q) begin
									run_limit_q <= req.page + 1'b1;
								end else begin
									// flush the old run before starting a new one
									if (run_open_q) begin
										ins_a_q <= run_first_q;
										ins_b_q <= run_limit_q;
										state_q <= S_IN_RD;
									end
									run_first_q <= req.page;
									run_limit_q <= req.page + 1'b1;
									run_open_q  <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_EMIT: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= '{out_page: '0, status: st_q, last: 1'b1};
						state_q     <= S_IDLE;
					end
				end
				S_AP: begin
					if (full) begin
						st_q    <= STS_FULL;
						state_q <= ret_state;
					end else begin
						slots_q <= slots_q + 1'b1;
						nx_q    <= new_idx;
						if (head_valid_q) begin
							state_q <= S_AP_TL;
						end else begin
							head_q       <= new_idx;
							head_valid_q <= 1'b1;
							tail_q       <= new_idx;
							state_q      <= ret_state;
						end
					end
				end
				S_AP_TL: begin
					tail_q  <= nx_q;
					state_q <= ret_state;
				end
				S_RV_RD: begin
					if (!have_q) begin
						st_q    <= STS_MISS;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_RV_CK;
					end
				end
				S_RV_CK: begin
					s_q  <= r_s;
					lk_q <= r_lk;
					hl_q <= r_hl;
					if (rv_hit) begin
						if (rv_trim) begin
							state_q <= S_EMIT;
							// unlink a drained extent
							if (rv_ns >= rv_ne) begin
								if (has_prev_q) begin
									state_q <= S_RV_UNL;
								end else begin
									head_q       <= r_lk;
									head_valid_q <= r_hl;
								end
							end
						end else if (full) begin
							st_q    <= STS_FULL;
							state_q <= S_EMIT;
						end else begin
							nx_q    <= new_idx;
							slots_q <= slots_q + 1'b1;
							state_q <= S_RV_SPL;
						end
					end else begin
						prev_q     <= cur_q;
						ps_q       <= r_s;
						pe_q       <= r_e;
						has_prev_q <= 1'b1;
						have_q     <= r_hl;
						cur_q      <= r_lk;
						state_q    <= S_RV_RD;
					end
				end
				S_RV_UNL: begin
					if (cur_q == tail_q) begin
						tail_q <= prev_q;
					end
					state_q <= S_EMIT;
				end
				S_RV_SPL: begin
					if (cur_q == tail_q) begin
						tail_q <= nx_q;
					end
					state_q <= S_EMIT;
				end
				S_AS_RD: begin
					if (!have_q || avail_q >= (PW+1)'(want_q)) begin
						if (avail_q < (PW+1)'(want_q)) begin
							st_q    <= STS_MISS;
							state_q <= S_EMIT;
						end else begin
							cur_q   <= head_q;
							have_q  <= head_valid_q;
							state_q <= S_AL_RD;
						end
					end else begin
						state_q <= S_AS_CK;
					end
				end
				S_AS_CK: begin
					avail_q <= avail_q + {1'b0, r_e - r_s};
					have_q  <= r_hl;
					cur_q   <= r_lk;
					state_q <= S_AS_RD;
				end
				S_AL_RD: begin
					state_q <= have_q ? S_AL_LD : S_IDLE;
				end
				S_AL_LD: begin
					s_q     <= r_s;
					e_q     <= r_e;
					lk_q    <= r_lk;
					hl_q    <= r_hl;
					state_q <= S_AL_RUN;
				end
				S_AL_RUN: begin
					if (s_q < e_q) begin
						if (out_free) begin
							rsp_valid_q <= 1'b1;
							rsp_q       <= '{out_page: s_q, status: STS_OK,
							                 last: (k_q + 1'b1) == want_q};
							s_q         <= s_q + 1'b1;
							k_q         <= k_q + 1'b1;
							if ((k_q + 1'b1) == want_q) begin
								state_q <= S_IDLE;
							end
						end
					end else begin
						have_q  <= hl_q;
						cur_q   <= lk_q;
						state_q <= S_AL_RD;
					end
				end
				S_IN_RD: begin
					state_q <= have_q ? S_IN_CK : S_AP;
				end
				S_IN_CK: begin
					s_q  <= r_s;
					e_q  <= ins_b_q;
					lk_q <= r_lk;
					hl_q <= r_hl;
					nx_q <= r_lk;
					if (r_s == ins_b_q) begin
						state_q <= ret_state;
					end else if (r_e == ins_a_q) begin
						state_q <= r_hl ? S_IN_MG : ret_state;
					end else begin
						have_q  <= r_hl;
						cur_q   <= r_lk;
						state_q <= S_IN_RD;
					end
				end
				S_IN_MG: begin
					if (mg_ok && nx_q == tail_q) begin
						tail_q <= cur_q;
					end
					state_q <= ret_state;
				end
				S_FR_NEXT: begin
					if (fin_pend_q && run_open_q) begin
						ins_a_q     <= run_first_q;
						ins_b_q     <= run_limit_q;
						run_open_q  <= 1'b0;
						run_first_q <= '0;
						run_limit_q <= '0;
						fin_pend_q  <= 1'b0;
						cur_q       <= head_q;
						have_q      <= head_valid_q;
						state_q     <= S_IN_RD;
					end else begin
						state_q <= S_EMIT;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sim/extent_list_page_allocator_unit_tb.sv
`timescale 1ns / 1ps

module extent_list_page_allocator_unit_tb;
	import elp_pkg::*;

	localparam int NSLOT = MAX_EXTENTS_DEF;
	localparam logic [PAGE_W-1:0] TOP_PAGE = PAGE_MASK;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	extent_list_page_allocator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// shadow of the extent table
	logic [PAGE_W-1:0] ext_lo [NSLOT];
	logic [PAGE_W-1:0] ext_hi [NSLOT];
	int unsigned       ext_nx [NSLOT];
	bit                ext_has_nx [NSLOT];
	int unsigned       head_idx, tail_idx, slots;
	bit                head_ok;
	logic [PAGE_W-1:0] run_lo, run_hi;
	bit                run_on;

	rsp_t expected_rsps[$];
	int   errors;
	int   rsp_seen;
	int   sent;
	bit   hold_rsp;
	bit   idle_ok;

	task automatic report(input string what);
		errors++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	function automatic void push_rsp(logic [PAGE_W-1:0] pg, logic [1:0] st, logic lst);
		rsp_t r;
		r.out_page = pg;
		r.status = st;
		r.last = lst;
		expected_rsps.push_back(r);
	endfunction

	function automatic void table_reset();
		for (int i = 0; i < NSLOT; i++) ext_has_nx[i] = 0;
		head_idx = 0; tail_idx = 0; slots = 0; head_ok = 0;
		run_lo = '0; run_hi = '0; run_on = 0;
	endfunction

	function automatic logic [1:0] add_extent(logic [PAGE_W-1:0] a, logic [PAGE_W-1:0] b);
		int unsigned idx;
		if (slots >= NSLOT) return STS_FULL;
		idx = slots++;
		ext_lo[idx] = a; ext_hi[idx] = b; ext_nx[idx] = 0; ext_has_nx[idx] = 0;
		if (head_ok) begin
			ext_nx[tail_idx] = idx; ext_has_nx[tail_idx] = 1;
		end else begin
			head_idx = idx; head_ok = 1;
		end
		tail_idx = idx;
		return STS_OK;
	endfunction

	function automatic logic [1:0] take_page(logic [PAGE_W-1:0] p);
		int unsigned cur, prv, idx;
		bit have, has_prv;
		logic [PAGE_W-1:0] s, e;
		cur = head_idx; have = head_ok; has_prv = 0; prv = 0;
		for (int n = 0; have && n < NSLOT; n++) begin
			s = ext_lo[cur]; e = ext_hi[cur];
			if (s <= p && p < e) begin
				if (p == s || p + 1 == e) begin
					if (p == s) ext_lo[cur] = s + 1;
					else ext_hi[cur] = e - 1;
					if (ext_lo[cur] >= ext_hi[cur]) begin
						if (has_prv) begin
							ext_nx[prv] = ext_nx[cur];
							ext_has_nx[prv] = ext_has_nx[cur];
							if (cur == tail_idx) tail_idx = prv;
						end else begin
							head_idx = ext_nx[cur];
							head_ok = ext_has_nx[cur];
						end
					end
					return STS_OK;
				end
				if (slots >= NSLOT) return STS_FULL;
				idx = slots++;
				ext_lo[idx] = p + 1; ext_hi[idx] = e;
				ext_nx[idx] = ext_nx[cur]; ext_has_nx[idx] = ext_has_nx[cur];
				ext_hi[cur] = p; ext_nx[cur] = idx; ext_has_nx[cur] = 1;
				if (cur == tail_idx) tail_idx = idx;
				return STS_OK;
			end
			prv = cur; has_prv = 1;
			have = ext_has_nx[cur];
			cur = ext_nx[cur];
		end
		return STS_MISS;
	endfunction

	function automatic logic [1:0] put_run(logic [PAGE_W-1:0] a, logic [PAGE_W-1:0] b);
		int unsigned cur, nx;
		bit have;
		cur = head_idx; have = head_ok;
		for (int n = 0; have && n < NSLOT; n++) begin
			if (ext_lo[cur] == b) begin
				ext_lo[cur] = a;
				return STS_OK;
			end
			if (ext_hi[cur] == a) begin
				ext_hi[cur] = b;
				if (ext_has_nx[cur]) begin
					nx = ext_nx[cur];
					if (ext_lo[nx] <= ext_hi[cur]) begin
						if (ext_hi[nx] > ext_hi[cur]) ext_hi[cur] = ext_hi[nx];
						ext_nx[cur] = ext_nx[nx];
						ext_has_nx[cur] = ext_has_nx[nx];
						if (nx == tail_idx) tail_idx = cur;
					end
				end
				return STS_OK;
			end
			have = ext_has_nx[cur];
			cur = ext_nx[cur];
		end
		return add_extent(a, b);
	endfunction

	function automatic void grant_pages(logic [PAGE_W-1:0] want);
		logic [PAGE_W+1:0] avail;
		int unsigned cur, k;
		bit have;
		if (want > MAX_ALLOC) begin
			push_rsp('0, STS_MISS, 1); return;
		end
		if (want == 0) begin
			push_rsp('0, STS_OK, 1); return;
		end
		avail = 0; cur = head_idx; have = head_ok;
		for (int n = 0; have && avail < want && n < NSLOT; n++) begin
			avail += ext_hi[cur] - ext_lo[cur];
			have = ext_has_nx[cur];
			cur = ext_nx[cur];
		end
		if (avail < want) begin
			push_rsp('0, STS_MISS, 1); return;
		end
		k = 0; cur = head_idx; have = head_ok;
		for (int n = 0; have && k < want && n < NSLOT; n++) begin
			while (k < want && ext_lo[cur] < ext_hi[cur]) begin
				push_rsp(ext_lo[cur], STS_OK, (k + 1 == want));
				ext_lo[cur] = ext_lo[cur] + 1;
				k++;
			end
			have = ext_has_nx[cur];
			cur = ext_nx[cur];
		end
	endfunction

	function automatic logic [1:0] release_page(logic [PAGE_W-1:0] q, logic fin);
		logic [1:0] st, r;
		st = STS_OK;
		if (q == TOP_PAGE) st = STS_MISS;
		else if (run_on && run_lo != 0 && q + 1 == run_lo) run_lo = q;
		else if (run_on && q == run_hi) run_hi = q + 1;
		else begin
			if (run_on) begin
				r = put_run(run_lo, run_hi);
				if (r > st) st = r;
			end
			run_lo = q; run_hi = q + 1; run_on = 1;
		end
		if (fin && run_on) begin
			r = put_run(run_lo, run_hi);
			if (r > st) st = r;
			run_on = 0; run_lo = '0; run_hi = '0;
		end
		return st;
	endfunction

	function automatic void predict(req_t q);
		logic [PAGE_W-1:0] e;
		logic [1:0] st;
		st = STS_OK;
		case (q.cmd)
			CMD_LOAD: begin
				e = (q.count > TOP_PAGE - q.page) ? TOP_PAGE : q.page + q.count;
				if (e > q.page) st = add_extent(q.page, e);
			end
			CMD_RESERVE: st = take_page(q.page);
			CMD_ALLOC: begin
				grant_pages(q.count);
				return;
			end
			default: st = release_page(q.page, q.final_req);
		endcase
		push_rsp('0, st, 1);
	endfunction

	function automatic logic [PAGE_W-1:0] rand_page();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("extent_list_page_allocator_unit_tb failed");
		$finish;
	end

	// response checker
	always @(posedge clk) begin
		rsp_t x;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_seen++;
			if (expected_rsps.size() == 0) report($sformatf("unexpected result %p", rsp));
			else begin
				x = expected_rsps.pop_front();
				if (rsp.out_page !== x.out_page)
					report($sformatf("out_page %h, want %h", rsp.out_page, x.out_page));
				if (rsp.status !== x.status)
					report($sformatf("status %0d, want %0d", rsp.status, x.status));
				if (rsp.last !== x.last)
					report($sformatf("last %0b, want %0b", rsp.last, x.last));
			end
		end
	end

	// receiver stall: random, free-running, or held off for a long stretch
	initial begin
		rsp_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_rsp) rsp_stall <= 1;
			else if (!idle_ok) rsp_stall <= 0;
			else rsp_stall <= ($urandom_range(99) < 23);
		end
	end

	task automatic send(req_t q);
		@(negedge clk);
		while (idle_ok && $urandom_range(99) < 23) begin
			req_valid <= 0;
			@(negedge clk);
		end
		req <= q;
		req_valid <= 1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict(q);
		sent++;
		@(negedge clk);
		req_valid <= 0;
	endtask

	function automatic req_t mk(logic [1:0] c, logic [PAGE_W-1:0] p, logic [PAGE_W-1:0] n,
			logic f);
		req_t q;
		q.cmd = c; q.page = p; q.count = n; q.final_req = f;
		return q;
	endfunction

	typedef struct {
		req_t q;
		bit   typed;
		rsp_t r;
	} row_t;

	row_t rows[$];

	task automatic row(req_t q, bit typed = 0, logic [1:0] st = STS_OK);
		row_t w;
		w.q = q; w.typed = typed;
		w.r.out_page = '0; w.r.status = st; w.r.last = 1;
		rows.push_back(w);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (expected_rsps.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	initial begin
		req_t q;
		logic [PAGE_W-1:0] base, p;
		int hold_cnt, loads;
		errors = 0; rsp_seen = 0; sent = 0; hold_rsp = 0; idle_ok = 0;
		arst_n = 0; req_valid = 0; req = '0;
		table_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed rows
		row(mk(CMD_ALLOC, '0, 1, 0), 1, STS_MISS);
		row(mk(CMD_RESERVE, 52'h100, 0, 0), 1, STS_MISS);
		row(mk(CMD_ALLOC, '0, '0, 0), 1, STS_OK);
		row(mk(CMD_ALLOC, '0, PAGE_MASK, 1), 1, STS_MISS);
		row(mk(CMD_LOAD, 52'h55, '0, 0), 1, STS_OK);
		row(mk(CMD_LOAD, 52'h100, 16, 0), 1, STS_OK);
		row(mk(CMD_LOAD, TOP_PAGE - 4, PAGE_MASK, 1), 1, STS_OK);
		row(mk(CMD_LOAD, TOP_PAGE, 5, 0), 1, STS_OK);
		row(mk(CMD_RESERVE, 52'h100, 0, 0));
		row(mk(CMD_RESERVE, 52'h10f, 0, 0));
		row(mk(CMD_RESERVE, 52'h108, 0, 1));
		row(mk(CMD_RESERVE, TOP_PAGE - 1, 0, 0));
		row(mk(CMD_ALLOC, '0, MAX_ALLOC + 1, 0), 1, STS_MISS);
		row(mk(CMD_ALLOC, '0, 9, 0));
		row(mk(CMD_FREE, TOP_PAGE, 0, 0), 1, STS_MISS);
		row(mk(CMD_FREE, 52'h103, 0, 0));
		row(mk(CMD_FREE, 52'h102, 0, 0));
		row(mk(CMD_FREE, 52'h104, 0, 0));
		row(mk(CMD_ALLOC, '0, 2, 0));
		row(mk(CMD_FREE, 52'h200, 0, 0));
		row(mk(CMD_FREE, 52'h101, 0, 1));
		row(mk(CMD_ALLOC, '0, MAX_ALLOC, 0));
		row(mk(CMD_ALLOC, '0, 3, 0));
		row(mk(CMD_FREE, '0, 0, 1));
		foreach (rows[i]) begin
			if (rows[i].typed) begin
				predict(rows[i].q);
				if (expected_rsps[$] != rows[i].r)
					report($sformatf("row %0d: model disagrees with typed result", i));
			end
		end
		table_reset();
		expected_rsps.delete();
		foreach (rows[i]) send(rows[i].q);
		drain();

		// random: mostly consistent sequences over a small page window
		idle_ok = 1;
		base = rand_page() & ~52'hFFFF;
		if (base > TOP_PAGE - 52'h20000) base = 52'h1000;
		loads = 0;
		for (int i = 0; i < 146; i++) begin
			if (i == 60) begin
				fork
					begin
						hold_rsp = 1;
						hold_cnt = 0;
						while (hold_cnt < 300) begin
							@(posedge clk);
							hold_cnt++;
						end
						hold_rsp = 0;
					end
				join_none
			end
			if (i > 100 && i < 130) idle_ok = 0;
			else idle_ok = 1;
			p = base + $urandom_range(0, 600);
			case ($urandom_range(0, 9))
				0, 1: begin
					q = mk(CMD_LOAD, p, $urandom_range(0, 40), $urandom_range(0, 1));
					loads++;
				end
				2, 3: q = mk(CMD_RESERVE, p, rand_page(), $urandom_range(0, 1));
				4, 5: q = mk(CMD_ALLOC, rand_page(), $urandom_range(0, MAX_ALLOC + 2),
						$urandom_range(0, 1));
				6, 7, 8: q = mk(CMD_FREE, p, rand_page(), ($urandom_range(0, 3) == 0));
				default: q = mk($urandom_range(0, 3), rand_page(), rand_page(),
						$urandom_range(0, 1));
			endcase
			send(q);
		end
		send(mk(CMD_FREE, base, '0, 1));
		drain();
		repeat (50) @(posedge clk);

		$display("covered %0d requests (%0d random loads), %0d results checked",
			sent, loads, rsp_seen);
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("extent_list_page_allocator_unit_tb passed");
		end else begin
			$display("extent_list_page_allocator_unit_tb failed");
		end
		$finish;
	end

endmodule

FILE: extent_list_page_allocator_unit.f
rtl/elp_pkg.sv
rtl/elp_ram.sv
rtl/extent_list_page_allocator_unit.sv
sim/extent_list_page_allocator_unit_tb.sv
